// File: sv/ictc_pkg.sv
package ictc_pkg;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] POS_MAX        = 16'hFFFF;
   localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
   localparam logic [3:0]  MIN_IHL        = 4'd5;

   typedef enum logic [1:0] {
      L4_NONE = 2'd0,
      L4_TCP  = 2'd1,
      L4_UDP  = 2'd2
   } l4_kind_type;

   // per-frame summary handed from the byte front end to the finishing stage
   typedef struct packed {
      logic        ipv4;
      logic [15:0] count;
      logic [3:0]  hdr_words;
      logic [15:0] total_len;
      logic [7:0]  proto;
      logic [15:0] hdr_sum;
      logic [15:0] seg_sum;
   } frame_sum_type;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// File: sv/ictc_front.sv
module ictc_front import ictc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_valid,
   input  logic [7:0]    frame_byte,
   input  logic          last_byte,
   output logic          sum_push,
   output frame_sum_type sum_data
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] ftype_ff, ftype_in;
   logic [3:0]  hw_ff, hw_in;
   logic [15:0] tl_ff, tl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] hsum_ff, hsum_in;
   logic [15:0] ssum_ff, ssum_in;
   logic [7:0]  held_ff, held_in;

   logic        active;
   logic        ip;
   logic        seg_on;
   logic [16:0] p17;
   logic [16:0] hdr_end;
   logic [16:0] seg_end;
   logic [15:0] word;

   always_comb begin
      active  = pos_ff != POS_MAX;
      ip      = (pos_ff >= ETH_HDR_BYTES) && (ftype_ff == ETHERTYPE_IPV4);
      seg_on  = ip && (hw_ff >= MIN_IHL);
      p17     = {1'b0, pos_ff};
      hdr_end = {1'b0, ETH_HDR_BYTES} + {11'd0, hw_ff, 2'b00};
      seg_end = {1'b0, ETH_HDR_BYTES} + {1'b0, tl_ff};
      word    = {held_ff, frame_byte};

      pos_in   = pos_ff;
      ftype_in = ftype_ff;
      hw_in    = hw_ff;
      tl_in    = tl_ff;
      proto_in = proto_ff;
      hsum_in  = hsum_ff;
      ssum_in  = ssum_ff;
      held_in  = held_ff;

      if (byte_valid && active) begin
         if (pos_ff == 16'd12) ftype_in = {frame_byte, 8'h00};
         if (pos_ff == 16'd13) ftype_in = {ftype_ff[15:8], frame_byte};
         if (ip && pos_ff == 16'd14) hw_in = frame_byte[3:0];
         if (ip && pos_ff == 16'd16) tl_in = {frame_byte, 8'h00};
         if (ip && pos_ff == 16'd17) tl_in = {tl_ff[15:8], frame_byte};
         if (ip && pos_ff == 16'd23) proto_in = frame_byte;

         if (!pos_ff[0]) begin
            held_in = frame_byte;
            // odd-length segment: pad the final byte with a low zero
            if (seg_on && p17 >= hdr_end && (p17 + 17'd1) == seg_end)
               ssum_in = oc_add(ssum_ff, {frame_byte, 8'h00});
         end else if (ip) begin
            if (pos_ff >= 16'd15 && p17 < hdr_end)
               hsum_in = oc_add(hsum_ff, word);
            // pseudo-header addresses and segment words never overlap
            if (pos_ff >= 16'd27 && pos_ff <= 16'd33)
               ssum_in = oc_add(ssum_ff, word);
            else if (seg_on && (p17 - 17'd1) >= hdr_end && p17 < seg_end)
               ssum_in = oc_add(ssum_ff, word);
         end
         pos_in = pos_ff + 16'd1;
      end

      sum_push           = byte_valid && last_byte;
      sum_data.count     = active ? pos_ff + 16'd1 : POS_MAX;
      sum_data.ipv4      = (sum_data.count >= ETH_HDR_BYTES) && (ftype_in == ETHERTYPE_IPV4);
      sum_data.hdr_words = hw_in;
      sum_data.total_len = tl_in;
      sum_data.proto     = proto_in;
      sum_data.hdr_sum   = hsum_in;
      sum_data.seg_sum   = ssum_in;

      // frame done: drop all per-frame state
      if (sum_push) begin
         pos_in   = '0;
         ftype_in = '0;
         hw_in    = '0;
         tl_in    = '0;
         proto_in = '0;
         hsum_in  = '0;
         ssum_in  = '0;
         held_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         ftype_ff <= '0;
         hw_ff    <= '0;
         tl_ff    <= '0;
         proto_ff <= '0;
         hsum_ff  <= '0;
         ssum_ff  <= '0;
         held_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         ftype_ff <= ftype_in;
         hw_ff    <= hw_in;
         tl_ff    <= tl_in;
         proto_ff <= proto_in;
         hsum_ff  <= hsum_in;
         ssum_ff  <= ssum_in;
         held_ff  <= held_in;
      end
   end

endmodule

// File: sv/ictc_queue.sv
module ictc_queue import ictc_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_sum_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output frame_sum_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_sum_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      full    = cnt_ff == CNT_W'(DEPTH);
      valid   = cnt_ff != '0;
      head    = slot_ff[rd_ff];
      do_push = push && !full;
      do_pop  = pop && valid;

      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CNT_W'(1);
      if (do_pop && !do_push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

endmodule

// File: sv/ictc_back.sv
module ictc_back import ictc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          sum_valid,
   input  frame_sum_type sum_data,
   output logic          sum_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic          rsp_is_ipv4,
   output logic [1:0]    rsp_l4_kind,
   output logic          rsp_ip_header_ok,
   output logic          rsp_l4_ok,
   output logic [15:0]   rsp_ip_residue,
   output logic [15:0]   rsp_l4_residue,
   output logic          rsp_malformed
);

   logic        out_valid_ff, out_valid_in;
   logic        ipv4_ff;
   l4_kind_type kind_ff;
   logic        ip_ok_ff;
   logic        l4_ok_ff;
   logic [15:0] ip_res_ff;
   logic [15:0] l4_res_ff;
   logic        bad_ff;

   l4_kind_type kind_in;
   logic        ip_ok_in;
   logic        l4_ok_in;
   logic [15:0] ip_res_in;
   logic [15:0] l4_res_in;
   logic        bad_in;
   logic [5:0]  hlen;
   logic [15:0] plen;
   logic [15:0] s1;
   logic [15:0] s2;
   logic        take;

   always_comb begin
      take         = sum_valid && (!out_valid_ff || rsp_pop);
      sum_pop      = take;
      out_valid_in = take || (out_valid_ff && !rsp_pop);

      hlen = {sum_data.hdr_words, 2'b00};
      plen = sum_data.total_len - {10'd0, hlen};
      s1   = oc_add(sum_data.seg_sum, {8'd0, sum_data.proto});
      s2   = oc_add(s1, plen);

      kind_in   = L4_NONE;
      ip_res_in = '0;
      l4_res_in = '0;
      bad_in    = 1'b0;
      if (sum_data.ipv4) begin
         ip_res_in = ~sum_data.hdr_sum;
         if (sum_data.proto == PROTO_TCP)      kind_in = L4_TCP;
         else if (sum_data.proto == PROTO_UDP) kind_in = L4_UDP;
         if (kind_in != L4_NONE) l4_res_in = ~s2;
         bad_in = ({1'b0, sum_data.count} < {1'b0, ETH_HDR_BYTES} + {11'd0, hlen})
               || ({1'b0, sum_data.count} < {1'b0, ETH_HDR_BYTES} + {1'b0, sum_data.total_len})
               || (sum_data.hdr_words < MIN_IHL)
               || (sum_data.total_len < {10'd0, hlen});
      end
      ip_ok_in = sum_data.ipv4 && (ip_res_in == '0);
      l4_ok_in = (kind_in != L4_NONE) && (l4_res_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ipv4_ff   <= sum_data.ipv4;
         kind_ff   <= kind_in;
         ip_ok_ff  <= ip_ok_in;
         l4_ok_ff  <= l4_ok_in;
         ip_res_ff <= ip_res_in;
         l4_res_ff <= l4_res_in;
         bad_ff    <= bad_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_is_ipv4      = ipv4_ff;
   assign rsp_l4_kind      = kind_ff;
   assign rsp_ip_header_ok = ip_ok_ff;
   assign rsp_l4_ok        = l4_ok_ff;
   assign rsp_ip_residue   = ip_res_ff;
   assign rsp_l4_residue   = l4_res_ff;
   assign rsp_malformed    = bad_ff;

endmodule

// File: sv/ipv4_tcp_udp_checksum_checker.sv
// Channel   Direction  Handshake         Payload
// req_      in         req_push/req_full  frame_byte[7:0], last_byte
// rsp_      out        rsp_pop/rsp_empty  is_ipv4, l4_kind, ok flags, residues, malformed
//
// One byte per clock while req_full is low; running sums update in the cycle the byte is taken.
// After its last byte, a frame's result passes through the queue, then the finishing register.
// req_full rises only while the frame-summary queue holds QUEUE_DEPTH frames.
// Synchronous reset clears all per-frame state and empties both queue and output.
module ipv4_tcp_udp_checksum_checker import ictc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_is_ipv4,
   output logic [1:0]  rsp_l4_kind,
   output logic        rsp_ip_header_ok,
   output logic        rsp_l4_ok,
   output logic [15:0] rsp_ip_residue,
   output logic [15:0] rsp_l4_residue,
   output logic        rsp_malformed
);

   logic          byte_valid;
   logic          sum_push;
   frame_sum_type sum_in;
   logic          q_full;
   logic          q_valid;
   logic          q_pop;
   frame_sum_type q_head;

   assign req_full   = q_full;
   assign byte_valid = req_push && !q_full;

   ictc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .frame_byte (req_frame_byte),
      .last_byte  (req_last_byte),
      .sum_push   (sum_push),
      .sum_data   (sum_in)
   );

   ictc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (sum_push),
      .push_data (sum_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   ictc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .sum_valid        (q_valid),
      .sum_data         (q_head),
      .sum_pop          (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_is_ipv4      (rsp_is_ipv4),
      .rsp_l4_kind      (rsp_l4_kind),
      .rsp_ip_header_ok (rsp_ip_header_ok),
      .rsp_l4_ok        (rsp_l4_ok),
      .rsp_ip_residue   (rsp_ip_residue),
      .rsp_l4_residue   (rsp_l4_residue),
      .rsp_malformed    (rsp_malformed)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top import ictc_pkg::*; ();

   typedef logic [7:0] octet_q_type[$];

   typedef struct packed {
      logic        is_ipv4;
      l4_kind_type kind;
      logic        ip_header_ok;
      logic        l4_ok;
      logic [15:0] ip_residue;
      logic [15:0] l4_residue;
      logic        malformed;
   } verdict_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_frame_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_is_ipv4;
   logic [1:0]  rsp_l4_kind;
   logic        rsp_ip_header_ok;
   logic        rsp_l4_ok;
   logic [15:0] rsp_ip_residue;
   logic [15:0] rsp_l4_residue;
   logic        rsp_malformed;

   // running per-frame state of the checker, mirrored here
   int unsigned frm_pos = 0;
   logic [15:0] frm_ethertype = '0;
   logic [3:0]  frm_ihl = '0;
   logic [15:0] frm_total_len = '0;
   logic [7:0]  frm_proto = '0;
   logic [15:0] frm_hdr_sum = '0;
   logic [15:0] frm_seg_sum = '0;
   logic [7:0]  frm_high_byte = '0;

   verdict_type expected_verdicts[$];
   int unsigned fail_count = 0;
   bit          tx_gaps = 1'b1;
   bit          rx_gaps = 1'b1;
   int unsigned pop_hold_request = 0;
   int unsigned pop_stall_left = 0;

   ipv4_tcp_udp_checksum_checker uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_frame_byte   (req_frame_byte),
      .req_last_byte    (req_last_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_is_ipv4      (rsp_is_ipv4),
      .rsp_l4_kind      (rsp_l4_kind),
      .rsp_ip_header_ok (rsp_ip_header_ok),
      .rsp_l4_ok        (rsp_l4_ok),
      .rsp_ip_residue   (rsp_ip_residue),
      .rsp_l4_residue   (rsp_l4_residue),
      .rsp_malformed    (rsp_malformed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("tb_top: FAIL");
      $finish;
   end

   // ones'-complement add with end-around carry
   function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] t;
      t = 32'(a) + 32'(b);
      return t[15:0] + t[31:16];
   endfunction

   // sum bytes as big-endian words; an odd trailing byte gets a zero low half
   function automatic logic [15:0] fold_bytes(input octet_q_type f, input int unsigned first_idx,
                                             input int unsigned end_idx, input logic [15:0] acc);
      for (int unsigned i = first_idx; i < end_idx; i += 2)
         acc = csum_add(acc, {f[i], (i + 1 < end_idx) ? f[i + 1] : 8'h00});
      return acc;
   endfunction

   task automatic predict_frame_byte(input logic [7:0] b, input logic last);
      int unsigned p, hdr_end, seg_end, count, hlen;
      bit          in_ip, seg_on;
      logic [15:0] word, plen;
      verdict_type v;
      p = frm_pos;
      if (p < POS_MAX) begin
         in_ip = p >= 14 && frm_ethertype == ETHERTYPE_IPV4;
         hdr_end = 14 + 4 * frm_ihl;
         seg_end = 14 + frm_total_len;
         seg_on = in_ip && frm_ihl >= MIN_IHL;
         if (p == 12) frm_ethertype = {b, 8'h00};
         if (p == 13) frm_ethertype[7:0] = b;
         if (in_ip && p == 14) frm_ihl = b[3:0];
         if (in_ip && p == 16) frm_total_len = {b, 8'h00};
         if (in_ip && p == 17) frm_total_len[7:0] = b;
         if (in_ip && p == 23) frm_proto = b;
         if (p % 2 == 0) begin
            frm_high_byte = b;
            // lone final byte of an odd-length segment
            if (seg_on && p >= hdr_end && p + 1 == seg_end)
               frm_seg_sum = csum_add(frm_seg_sum, {b, 8'h00});
         end else if (in_ip) begin
            word = {frm_high_byte, b};
            hdr_end = 14 + 4 * frm_ihl;
            if (p - 1 >= 14 && p < hdr_end) frm_hdr_sum = csum_add(frm_hdr_sum, word);
            // source and destination addresses enter the pseudo-header
            if (p >= 27 && p <= 33) frm_seg_sum = csum_add(frm_seg_sum, word);
            if (seg_on && p - 1 >= hdr_end && p < seg_end)
               frm_seg_sum = csum_add(frm_seg_sum, word);
         end
         frm_pos = p + 1;
      end
      if (last) begin
         count = (p < POS_MAX) ? p + 1 : POS_MAX;
         v = '0;
         if (count >= 14 && frm_ethertype == ETHERTYPE_IPV4) begin
            hlen = 4 * frm_ihl;
            plen = 16'(frm_total_len - hlen);
            v.is_ipv4 = 1'b1;
            v.ip_residue = ~frm_hdr_sum;
            v.ip_header_ok = v.ip_residue == 16'h0000;
            v.malformed = count < 14 + hlen || count < 14 + frm_total_len ||
                          frm_ihl < MIN_IHL || frm_total_len < hlen;
            if (frm_proto == PROTO_TCP) v.kind = L4_TCP;
            else if (frm_proto == PROTO_UDP) v.kind = L4_UDP;
            if (v.kind != L4_NONE) begin
               v.l4_residue = ~csum_add(csum_add(frm_seg_sum, {8'h00, frm_proto}), plen);
               v.l4_ok = v.l4_residue == 16'h0000;
            end
         end
         expected_verdicts.push_back(v);
         frm_pos = 0;
         frm_ethertype = '0;
         frm_ihl = '0;
         frm_total_len = '0;
         frm_proto = '0;
         frm_hdr_sum = '0;
         frm_seg_sum = '0;
         frm_high_byte = '0;
      end
   endtask

   task automatic check_verdict(input verdict_type want);
      if (rsp_is_ipv4 !== want.is_ipv4) begin
         $error("is_ipv4: expected %0d, got %0d", want.is_ipv4, rsp_is_ipv4);
         fail_count++;
      end
      if (rsp_l4_kind !== want.kind) begin
         $error("l4_kind: expected %0d, got %0d", want.kind, rsp_l4_kind);
         fail_count++;
      end
      if (rsp_ip_header_ok !== want.ip_header_ok) begin
         $error("ip_header_ok: expected %0d, got %0d", want.ip_header_ok, rsp_ip_header_ok);
         fail_count++;
      end
      if (rsp_l4_ok !== want.l4_ok) begin
         $error("l4_ok: expected %0d, got %0d", want.l4_ok, rsp_l4_ok);
         fail_count++;
      end
      if (rsp_ip_residue !== want.ip_residue) begin
         $error("ip_residue: expected %h, got %h", want.ip_residue, rsp_ip_residue);
         fail_count++;
      end
      if (rsp_l4_residue !== want.l4_residue) begin
         $error("l4_residue: expected %h, got %h", want.l4_residue, rsp_l4_residue);
         fail_count++;
      end
      if (rsp_malformed !== want.malformed) begin
         $error("malformed: expected %0d, got %0d", want.malformed, rsp_malformed);
         fail_count++;
      end
   endtask

   // check the result transfer first, then account for the byte transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_verdicts.size() == 0) begin
               $error("result transfer with no frame pending");
               fail_count++;
            end else begin
               check_verdict(expected_verdicts.pop_front());
            end
         end
         if (req_push && !req_full) predict_frame_byte(req_frame_byte, req_last_byte);
      end
   end

   // result side: random stall bursts, plus long holds on request
   always @(posedge clock) begin
      if (pop_hold_request != 0) begin
         pop_stall_left = pop_hold_request;
         pop_hold_request = 0;
      end else if (pop_stall_left == 0 && rx_gaps && $urandom_range(0, 15) == 0) begin
         pop_stall_left = $urandom_range(1, 16);
      end
      if (pop_stall_left != 0) begin
         rsp_pop <= 1'b0;
         pop_stall_left--;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      if (tx_gaps && $urandom_range(0, 15) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_frame_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_frame(input octet_q_type f);
      foreach (f[i]) push_byte(f[i], i == f.size() - 1);
   endtask

   task automatic wait_for_verdicts();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // IPv4 frame with random addresses and content; seal fills in valid checksums
   task automatic make_frame(output octet_q_type f, input logic [3:0] ihl, input logic [7:0] proto,
                             input int unsigned payload_len, input int unsigned pad_len,
                             input bit seal);
      int unsigned hlen, seg_start, slot;
      logic [15:0] total, s;
      hlen = 4 * ihl;
      total = 16'(hlen + payload_len);
      f = {};
      repeat (12) f.push_back(8'($urandom));
      f.push_back(ETHERTYPE_IPV4[15:8]);
      f.push_back(ETHERTYPE_IPV4[7:0]);
      f.push_back({4'h4, ihl});
      f.push_back(8'($urandom));
      f.push_back(total[15:8]);
      f.push_back(total[7:0]);
      repeat (5) f.push_back(8'($urandom));
      f.push_back(proto);
      repeat (10) f.push_back(8'($urandom));
      repeat ((ihl > MIN_IHL) ? hlen - 20 : 0) f.push_back(8'($urandom));
      seg_start = f.size();
      repeat (payload_len) f.push_back(8'($urandom));
      if (seal && ihl >= MIN_IHL) begin
         f[24] = 8'h00;
         f[25] = 8'h00;
         s = ~fold_bytes(f, 14, 14 + hlen, 16'h0000);
         f[24] = s[15:8];
         f[25] = s[7:0];
         if ((proto == PROTO_TCP || proto == PROTO_UDP) && payload_len >= 2) begin
            slot = seg_start + ((proto == PROTO_UDP && payload_len >= 8) ? 6 :
                                (proto == PROTO_TCP && payload_len >= 18) ? 16 : 0);
            f[slot] = 8'h00;
            f[slot + 1] = 8'h00;
            s = fold_bytes(f, 26, 34, {8'h00, proto});
            s = csum_add(s, 16'(payload_len));
            s = ~fold_bytes(f, seg_start, seg_start + payload_len, s);
            f[slot] = s[15:8];
            f[slot + 1] = s[7:0];
         end
      end
      repeat (pad_len) f.push_back(8'($urandom));
   endtask

   // mostly sealed TCP/UDP datagrams; the rest corrupted, cut short, short-header or noise
   task automatic make_random_frame(output octet_q_type f);
      int unsigned pick, k, cut;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      pick = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : MIN_IHL;
      k = $urandom_range(0, 9);
      if (k == 0) proto = 8'($urandom);
      else if (k < 6) proto = PROTO_TCP;
      else proto = PROTO_UDP;
      if (pick < 75) begin
         make_frame(f, ihl, proto, $urandom_range(0, 24),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0, 1'b1);
         if (pick < 60 && $urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, f.size() - 1);
            f[k] = f[k] ^ (8'h01 << $urandom_range(0, 7));
         end else if (pick >= 60) begin
            cut = $urandom_range(1, f.size());
            while (f.size() > cut) void'(f.pop_back());
         end
      end else if (pick < 85) begin
         make_frame(f, 4'($urandom_range(0, 4)), proto, $urandom_range(0, 24), 0, 1'b0);
      end else begin
         f = {};
         repeat ($urandom_range(1, 60)) f.push_back(8'($urandom));
         if (f.size() > 13 && $urandom_range(0, 1) == 1) begin
            f[12] = ETHERTYPE_IPV4[15:8];
            f[13] = ETHERTYPE_IPV4[7:0];
         end
      end
   endtask

   task automatic test_directed();
      octet_q_type f;
      f = {8'hFF};
      send_frame(f);
      // runt: ends one byte before the ethertype is complete
      make_frame(f, MIN_IHL, PROTO_TCP, 20, 0, 1'b1);
      while (f.size() > 13) void'(f.pop_back());
      send_frame(f);
      // ethernet header only
      make_frame(f, MIN_IHL, PROTO_TCP, 20, 0, 1'b1);
      while (f.size() > 14) void'(f.pop_back());
      send_frame(f);
      make_frame(f, MIN_IHL, PROTO_TCP, 20, 0, 1'b1);
      for (int i = 0; i < 6; i++) begin
         f[i] = 8'hFF;
         f[i + 6] = 8'h00;
      end
      send_frame(f);
      // odd UDP payload followed by link padding
      make_frame(f, MIN_IHL, PROTO_UDP, 9, 6, 1'b1);
      send_frame(f);
      make_frame(f, MIN_IHL, 8'd1, 8, 0, 1'b1);
      send_frame(f);
      make_frame(f, 4'd15, PROTO_TCP, 21, 0, 1'b1);
      send_frame(f);
      // header length below the minimum
      make_frame(f, 4'd3, PROTO_UDP, 10, 0, 1'b0);
      send_frame(f);
      // datagram cut short
      make_frame(f, MIN_IHL, PROTO_UDP, 16, 0, 1'b1);
      while (f.size() > 40) void'(f.pop_back());
      send_frame(f);
      // total length smaller than the header
      make_frame(f, MIN_IHL, PROTO_TCP, 12, 0, 1'b1);
      f[16] = 8'h00;
      f[17] = 8'h0A;
      send_frame(f);
      make_frame(f, MIN_IHL, PROTO_UDP, 12, 0, 1'b1);
      f[20] = f[20] ^ 8'h80;
      send_frame(f);
      // empty UDP datagram padded to the minimum frame size
      make_frame(f, MIN_IHL, PROTO_UDP, 0, 26, 1'b1);
      send_frame(f);
      wait_for_verdicts();
   endtask

   task automatic test_backpressure();
      octet_q_type f;
      tx_gaps = 1'b0;
      pop_hold_request = 300;
      repeat (12) begin
         make_frame(f, MIN_IHL, PROTO_UDP, $urandom_range(0, 8), 0, 1'b1);
         send_frame(f);
      end
      tx_gaps = 1'b1;
      wait_for_verdicts();
   endtask

   task automatic test_random_frames();
      octet_q_type f;
      int unsigned bytes_sent, frames_sent;
      bytes_sent = 0;
      frames_sent = 0;
      while (bytes_sent < 500 || frames_sent < 12) begin
         make_random_frame(f);
         send_frame(f);
         bytes_sent += f.size();
         frames_sent++;
      end
      wait_for_verdicts();
   endtask

   task automatic test_steady_stream();
      octet_q_type f;
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      repeat (10) begin
         make_random_frame(f);
         send_frame(f);
      end
      wait_for_verdicts();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_frames();
      test_steady_stream();
      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// File: ipv4_tcp_udp_checksum_checker.f
sv/ictc_pkg.sv
sv/ictc_front.sv
sv/ictc_queue.sv
sv/ictc_back.sv
sv/ipv4_tcp_udp_checksum_checker.sv
tb/tb_top.sv
